// ===== hw/rtl/pci_pkg.sv =====
// Shared widths, register indexes and helpers for the PID conditional integration unit.
package pci_pkg;

  // Operand width of the shared multiplier (Q16.16 plus headroom for unsigned operands)
  localparam int unsigned MulW     = 33;
  localparam int unsigned ProdW    = 2 * MulW;
  // Divider: dividend is |difference| << 16, divisor is the sample interval
  localparam int unsigned DivNumW  = 48;
  localparam int unsigned DivDenW  = 16;
  localparam int unsigned DivCntW  = 6;

  // Configuration register indexes
  localparam logic [2:0] RegGainP   = 3'd0;
  localparam logic [2:0] RegGainI   = 3'd1;
  localparam logic [2:0] RegGainD   = 3'd2;
  localparam logic [2:0] RegFloor   = 3'd3;
  localparam logic [2:0] RegCeil    = 3'd4;
  localparam logic [2:0] RegLimits  = 3'd5;
  localparam logic [2:0] RegDeadZn  = 3'd6;
  localparam logic [2:0] RegWeight  = 3'd7;

  localparam logic [16:0] OneQ16 = 17'd65536;

  // Divider handshake toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Saturate a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] x);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    begin
      hi = ProdW'(32'sh7FFF_FFFF);
      lo = -ProdW'(33'sh0_8000_0000);
      if (x > hi) begin
        sat32 = 32'sh7FFF_FFFF;
      end else if (x < lo) begin
        sat32 = 32'sh8000_0000;
      end else begin
        sat32 = x[31:0];
      end
    end
  endfunction

endpackage

// ===== hw/rtl/pci_mul.sv =====
// Shared signed multiplier with registered product.
module pci_mul
  import pci_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  // One product per cycle, available the cycle after issue
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/pci_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module pci_div
  import pci_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output div_status_t        stat_o,
  output logic [DivNumW-1:0] quot_o
);

  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivNumW-1:0]  quot_q, quot_d;
  logic [DivDenW:0]    rem_q, rem_d;
  logic [DivDenW-1:0]  den_q, den_d;
  logic [DivDenW:0]    rem_sh;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q[DivDenW-1:0], quot_q[DivNumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNumW);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quot_d = {quot_q[DivNumW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d     = rem_sh - {1'b0, den_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = rem_sh;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;

endmodule

// ===== hw/rtl/pid_conditional_integration_unit.sv =====
// An item with a derivative runs through the divide and the multiplier steps before drive is
// valid; the first sample skips the divide, and a zero interval goes straight to the output.
// Items are handled one at a time; the next input transfer can be taken in the cycle after the
// result transfer.
// Reset (rst_ni low, asynchronous) clears integral, history and loads register defaults.
// Top level: sequencer around the shared multiplier and divider.
module pid_conditional_integration_unit
  import pci_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] error_in, [47:32] interval
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] drive
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StPre  = 4'd1;
  localparam logic [3:0] StEdt  = 4'd2;
  localparam logic [3:0] StCand = 4'd3;
  localparam logic [3:0] StStep = 4'd4;
  localparam logic [3:0] StP    = 4'd5;
  localparam logic [3:0] StI    = 4'd6;
  localparam logic [3:0] StWait = 4'd7;
  localparam logic [3:0] StF1   = 4'd8;
  localparam logic [3:0] StF2   = 4'd9;
  localparam logic [3:0] StF3   = 4'd10;
  localparam logic [3:0] StD    = 4'd11;
  localparam logic [3:0] StSum  = 4'd12;
  localparam logic [3:0] StOut  = 4'd13;

  // Configuration registers
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, floor_q, ceil_q, lim_lo_q, lim_hi_q;
  logic [30:0]        dead_zone_q;
  logic [16:0]        weight_q;

  // Controller state
  logic signed [31:0] integral_q, last_err_q, last_slope_q;
  logic               have_last_q;

  // Working registers
  logic [3:0]          state_q;
  logic signed [31:0]  err_q, cand_q, step_q, raw_q, slope_q, drive_q;
  logic [15:0]         dt_q;
  logic                diff_neg_q;
  logic signed [33:0]  acc_q;
  logic signed [ProdW-1:0] facc_q;

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [31:0]      prod_q16;
  logic signed [31:0]      diff;
  logic [31:0]             diff_abs;
  logic [31:0]             err_abs;
  logic                    div_start;
  div_status_t             div_stat;
  logic [DivNumW-1:0]      quot;
  logic signed [31:0]      raw_sat;
  logic signed [31:0]      cand_sum;
  logic signed [31:0]      cand_clamp;
  logic signed [31:0]      slope_new;
  logic signed [31:0]      drive_sum;
  logic                    keep_cand;

  pci_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pci_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({diff_abs, 16'b0}),
    .den_i  (dt_q),
    .stat_o (div_stat),
    .quot_o (quot)
  );

  // Product in Q16.16, floored and saturated
  assign prod_q16 = sat32(prod >>> 16);

  assign err_abs  = err_q[31] ? (32'd0 - 32'(err_q)) : 32'(err_q);
  assign diff     = sat32(ProdW'(err_q) - ProdW'(last_err_q));
  assign diff_abs = diff[31] ? (32'd0 - 32'(diff)) : 32'(diff);
  assign div_start = (state_q == StEdt) && have_last_q;

  // Signed, saturated derivative quotient
  always_comb begin
    if (diff_neg_q) begin
      if (quot > DivNumW'(33'h0_8000_0000)) begin
        raw_sat = 32'sh8000_0000;
      end else begin
        raw_sat = 32'(32'd0 - quot[31:0]);
      end
    end else if (quot > DivNumW'(32'h7FFF_FFFF)) begin
      raw_sat = 32'sh7FFF_FFFF;
    end else begin
      raw_sat = quot[31:0];
    end
  end

  // Integral candidate, clamped to its limits
  always_comb begin
    cand_sum = sat32(ProdW'(integral_q) + ProdW'(prod_q16));
    if (cand_sum < lim_lo_q) begin
      cand_clamp = lim_lo_q;
    end else if (cand_sum > lim_hi_q) begin
      cand_clamp = lim_hi_q;
    end else begin
      cand_clamp = cand_sum;
    end
  end

  assign slope_new = sat32((facc_q + prod) >>> 16);
  assign drive_sum = sat32(ProdW'(acc_q) + ProdW'(prod_q16));
  assign keep_cand = !((drive_sum > ceil_q && step_q > 0) || (drive_sum < floor_q && step_q < 0));

  // Multiplier operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StEdt: begin
        mul_a = MulW'(err_q);
        mul_b = $signed({17'b0, dt_q});
      end
      StStep: begin
        mul_a = MulW'(gain_i_q);
        mul_b = MulW'(sat32(ProdW'(cand_q) - ProdW'(integral_q)));
      end
      StP: begin
        mul_a = MulW'(gain_p_q);
        mul_b = MulW'(err_q);
      end
      StI: begin
        mul_a = MulW'(gain_i_q);
        mul_b = MulW'(cand_q);
      end
      StF1: begin
        mul_a = $signed({16'b0, weight_q});
        mul_b = MulW'(raw_q);
      end
      StF2: begin
        mul_a = $signed({16'b0, OneQ16 - weight_q});
        mul_b = MulW'(last_slope_q);
      end
      StD: begin
        mul_a = MulW'(gain_d_q);
        mul_b = MulW'(slope_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer, controller state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      floor_q      <= 32'sh8000_0000;
      ceil_q       <= 32'sh7FFF_FFFF;
      lim_lo_q     <= 32'sh8000_0000;
      lim_hi_q     <= 32'sh7FFF_FFFF;
      dead_zone_q  <= '0;
      weight_q     <= OneQ16;
      integral_q   <= '0;
      last_err_q   <= '0;
      last_slope_q <= '0;
      have_last_q  <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            state_q <= (s_axis_tdata[47:32] == 16'd0) ? StOut : StPre;
          end
        end
        StPre: begin
          if (err_abs <= {1'b0, dead_zone_q}) begin
            integral_q <= '0;
          end
          state_q <= StEdt;
        end
        StEdt:  state_q <= StCand;
        StCand: state_q <= StStep;
        StStep: state_q <= StP;
        StP:    state_q <= StI;
        StI:    state_q <= StWait;
        StWait: begin
          if (!have_last_q) begin
            state_q <= StD;
          end else if (div_stat.done) begin
            state_q <= StF1;
          end
        end
        StF1: state_q <= StF2;
        StF2: state_q <= StF3;
        StF3: state_q <= StD;
        StD:  state_q <= StSum;
        StSum: begin
          if (keep_cand) begin
            integral_q <= cand_q;
          end
          last_err_q   <= err_q;
          last_slope_q <= slope_q;
          have_last_q  <= 1'b1;
          state_q      <= StOut;
        end
        StOut: begin
          if (m_axis_tready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase

      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGainP: gain_p_q <= cfg_data_i[31:0];
          RegGainI: begin
            gain_i_q <= cfg_data_i[31:0];
            if (cfg_data_i[31:0] == 32'd0) begin
              integral_q <= '0;
            end
          end
          RegGainD:  gain_d_q <= cfg_data_i[31:0];
          RegFloor:  floor_q  <= cfg_data_i[31:0];
          RegCeil:   ceil_q   <= cfg_data_i[31:0];
          RegLimits: begin
            lim_lo_q <= cfg_data_i[31:0];
            lim_hi_q <= cfg_data_i[63:32];
          end
          RegDeadZn: dead_zone_q <= cfg_data_i[30:0];
          RegWeight: weight_q <= (cfg_data_i[16:0] > OneQ16) ? OneQ16 : cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        err_q   <= s_axis_tdata[31:0];
        dt_q    <= s_axis_tdata[47:32];
        drive_q <= '0;
        slope_q <= '0;
      end
      StPre: begin
        if (err_abs <= {1'b0, dead_zone_q}) begin
          err_q <= '0;
        end
      end
      StEdt:  diff_neg_q <= diff[31];
      StCand: cand_q <= cand_clamp;
      StP:    step_q <= prod_q16;
      StI:    acc_q  <= 34'(prod_q16);
      StWait: begin
        acc_q <= acc_q + 34'(prod_q16);
        raw_q <= raw_sat;
      end
      StF2: facc_q  <= prod;
      StF3: slope_q <= slope_new;
      StSum: begin
        if (drive_sum < floor_q) begin
          drive_q <= floor_q;
        end else if (drive_sum > ceil_q) begin
          drive_q <= ceil_q;
        end else begin
          drive_q <= drive_sum;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = drive_q;

  // Input and output sides never open together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open together");

  // Divider only runs inside an item
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_stat.busy |-> state_q != StIdle)
    else $error("divider busy while idle");

  // Zero integral gain write clears the integral
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == RegGainI && cfg_data_i[31:0] == 32'd0) |=> integral_q == 0)
    else $error("integral not cleared");

  // A zero interval leaves the history untouched and gives a zero drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[47:32] == 16'd0)
      |=> $stable(have_last_q) && m_axis_tvalid && m_axis_tdata == 32'd0)
    else $error("zero interval changed state");

endmodule

// ===== test/pid_conditional_integration_unit_tb.sv =====
// Self-checking testbench for the PID conditional integration unit.
module pid_conditional_integration_unit_tb;
  import pci_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // [31:0] error_in, [47:32] interval
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] drive
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  localparam int unsigned IdleLimit = 20000;

  pid_conditional_integration_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Shadow of the controller: registers and state
  longint kp, ki, kd, out_lo, out_hi, int_lo, int_hi, dz, alpha;
  longint integ, prev_err, prev_slope;
  bit     primed;

  logic [31:0] drive_q[$];
  int unsigned mismatches, drives_seen, items_sent, idle_cycles;
  int unsigned burst_left;

  function automatic longint sat_w(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Arithmetic shift gives floor rounding
  function automatic longint fl16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat_w(fl16(a * b));
  endfunction

  function automatic longint s32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic shadow_reset();
    kp = 0; ki = 0; kd = 0;
    out_lo = -64'sd2147483648; out_hi = 64'sd2147483647;
    int_lo = -64'sd2147483648; int_hi = 64'sd2147483647;
    dz = 0; alpha = 65536;
    integ = 0; prev_err = 0; prev_slope = 0; primed = 0;
  endtask

  task automatic shadow_write(logic [2:0] idx, logic [63:0] v);
    case (idx)
      RegGainP: kp = s32(v[31:0]);
      RegGainI: begin
        ki = s32(v[31:0]);
        if (ki == 0) integ = 0;
      end
      RegGainD:  kd = s32(v[31:0]);
      RegFloor:  out_lo = s32(v[31:0]);
      RegCeil:   out_hi = s32(v[31:0]);
      RegLimits: begin
        int_lo = s32(v[31:0]);
        int_hi = s32(v[63:32]);
      end
      RegDeadZn: dz = longint'(v[30:0]);
      RegWeight: alpha = (v[16:0] > OneQ16) ? 65536 : longint'(v[16:0]);
      default: ;
    endcase
  endtask

  // One controller step; returns the expected drive
  function automatic logic [31:0] pid_drive(logic [31:0] err_v, logic [15:0] dt_v);
    longint e, dt, slope, cand, stp, drv, diff, raw;
    e = s32(err_v);
    dt = longint'(dt_v);
    slope = 0;
    if (dt == 0) return 32'd0;
    if ((e < 0 ? -e : e) <= dz) begin
      e = 0;
      integ = 0;
    end
    if (primed) begin
      diff = sat_w(e - prev_err);
      raw = sat_w((diff * 65536) / dt);
      slope = sat_w(fl16(alpha * raw + (65536 - alpha) * prev_slope));
    end
    cand = sat_w(integ + sat_w(fl16(e * dt)));
    if (cand < int_lo) cand = int_lo;
    else if (cand > int_hi) cand = int_hi;
    stp = fx_mul(ki, sat_w(cand - integ));
    drv = sat_w(fx_mul(kp, e) + fx_mul(ki, cand) + fx_mul(kd, slope));
    if (!((drv > out_hi && stp > 0) || (drv < out_lo && stp < 0))) integ = cand;
    if (drv < out_lo) drv = out_lo;
    else if (drv > out_hi) drv = out_hi;
    prev_err = e;
    prev_slope = slope;
    primed = 1;
    return drv[31:0];
  endfunction

  always #4 clk_i = ~clk_i;

  // Output side: random stall pattern, check each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        drives_seen++;
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected drive %h", m_axis_tdata);
        end else begin
          want = drive_q.pop_front();
          if (want !== m_axis_tdata) begin
            mismatches++;
            if (mismatches <= 10)
              $display("drive mismatch: expected %h actual %h", want, m_axis_tdata);
          end
        end
      end
      // random stalls, with a free-running stretch in every third run of 64 drives
      m_axis_tready <= ((drives_seen / 64) % 3 == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired");
      $display("pid_conditional_integration_unit regression: fail");
      $finish;
    end
  end

  // Send one item; gaps come from the burst pattern, valid stays up inside a burst
  task automatic send_sample(logic [31:0] err_v, logic [15:0] dt_v);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt_v, err_v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    drive_q.push_back(pid_drive(err_v, dt_v));
    items_sent++;
  endtask

  // Close the input and wait for the pipe to drain before register writes
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    shadow_write(idx, v);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_err();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 24'h3FFFFF)) - 32'sh200000);
    endcase
  endfunction

  function automatic logic [15:0] rand_dt();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 4));
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // Directed: edges of fields, zero interval, first sample, dead zone, weight, limits, zero integral gain
  task automatic test_directed();
    write_reg(RegGainP, 64'h0001_0000);
    write_reg(RegGainI, 64'h0000_8000);
    write_reg(RegGainD, 64'h0000_0100);
    send_sample(32'h0001_0000, 16'd0);
    send_sample(32'h0001_0000, 16'h1000);
    send_sample(32'h7FFF_FFFF, 16'hFFFF);
    send_sample(32'h8000_0000, 16'd1);
    send_sample(32'h8000_0000, 16'd1);
    send_sample(32'h7FFF_FFFF, 16'd1);
    send_sample(32'h0000_0000, 16'h8000);
    send_sample(32'hFFFF_FFFF, 16'h0001);
    drain();
    write_reg(RegDeadZn, 64'h0000_0000_7FFF_FFFF);
    send_sample(32'h1234_5678, 16'h0100);
    send_sample(32'h8000_0000, 16'h0100);
    drain();
    write_reg(RegDeadZn, 64'h0000_0000_0001_0000);
    send_sample(32'h0001_0000, 16'h0100);
    send_sample(32'hFFFF_0000, 16'h0100);
    send_sample(32'h0001_0001, 16'h0100);
    drain();
    write_reg(RegWeight, 64'h0000_0000_0001_FFFF);
    write_reg(RegWeight, 64'd0);
    write_reg(RegFloor, 64'hFFFF_FFFF_FFFF_0000);
    write_reg(RegCeil, 64'h0000_0000_0001_0000);
    write_reg(RegLimits, 64'h0000_8000_FFFF_8000);
    send_sample(32'h0100_0000, 16'h4000);
    send_sample(32'h0100_0000, 16'h4000);
    send_sample(32'hFF00_0000, 16'h4000);
    send_sample(32'hFF00_0000, 16'h4000);
    drain();
    write_reg(RegGainI, 64'd0);
    write_reg(RegWeight, 64'h0000_0000_0000_8000);
    send_sample(32'h0002_0000, 16'h2000);
    send_sample(32'h0004_0000, 16'h0001);
    drain();
  endtask

  // Random phases with random registers, extremes included
  task automatic test_random(int unsigned n_items);
    logic [63:0] v;
    for (int ph = 0; ph < 12; ph++) begin
      drain();
      for (int r = 0; r < 8; r++) begin
        v = {$urandom, $urandom};
        if (r < 3 && $urandom_range(0, 2) == 0) v = {32'd0, $urandom_range(0, 1) ? 32'h0001_0000
                                                  : 32'($urandom_range(0, 131071)) - 32'd65536};
        if (ph == 0) v = (r == 3) ? 64'h8000_0000 : (r == 4 ? 64'h7FFF_FFFF
                         : (r == 5 ? 64'h7FFF_FFFF_8000_0000 : v));
        if (ph == 1 && r == 6) v = 64'd0;
        if (ph == 2 && r == 7) v = 64'd65536;
        if (r == 6 && ph > 2) v = $urandom_range(0, 3) ? 64'($urandom_range(0, 32'h20000)) : v;
        if (r == 7 && ph > 2) v = 64'($urandom_range(0, 17'h1FFFF));
        if ($urandom_range(0, 3) != 0 || ph < 3) write_reg(3'(r), v);
      end
      for (int i = 0; i < n_items / 12; i++) send_sample(rand_err(), rand_dt());
    end
  endtask

  initial begin
    clk_i = 0;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    mismatches = 0; drives_seen = 0; items_sent = 0; idle_cycles = 0; burst_left = 0;
    shadow_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1836);
    drain();
    $display("covered %0d samples and %0d drives over directed and random register sets",
             items_sent, drives_seen);
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("pid_conditional_integration_unit regression: pass");
    end else begin
      $display("%0d mismatches, %0d drives missing", mismatches, drive_q.size());
      $display("pid_conditional_integration_unit regression: fail");
    end
    $finish;
  end

endmodule
